### src/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants of the stack insertion sorter
// Default sizes, the cell operation code, the per-cell control bundle and the
// sequencer states.
// ----------------------------------------------------------------------------
package sis_pkg;

    // Default sizes
    localparam int SIS_DEPTH      = 16;
    localparam int SIS_DATA_WIDTH = 32;

    // Operation applied to every cell in one cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    // Control bundle from the sequencer to one cell
    typedef struct packed {
        cell_op_t op;
        logic     occupied;     // cell holds a stored value
        logic     upper_keep;   // neighbor above keeps its value on insert
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } sis_state_t;

endpackage

### src/sis_if.sv
// ----------------------------------------------------------------------------
// sis_if: item channels of the stack insertion sorter
// Valid/ready channels for the incoming values and for the sorted results.
// ----------------------------------------------------------------------------

// Input channel: one value per item, flag on the final value of a run
interface sis_in_if #(
    parameter int DATA_WIDTH = sis_pkg::SIS_DATA_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         end_of_run;

    modport source (output valid, value, end_of_run, input ready);
    modport sink   (input valid, value, end_of_run, output ready);
endinterface

// Output channel: sorted values, largest first
interface sis_out_if #(
    parameter int DATA_WIDTH = sis_pkg::SIS_DATA_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last;
    logic                         overflow;

    modport source (output valid, sorted_value, last, overflow, input ready);
    modport sink   (input valid, sorted_value, last, overflow, output ready);
endinterface

### src/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell: one compare-and-shift cell of the sorting chain
// Holds one value. On insert it keeps its value, takes the new value or takes
// the value of the cell above; on pop it takes the value of the cell below.
// ----------------------------------------------------------------------------
module sis_cell #(
    parameter int DATA_WIDTH = sis_pkg::SIS_DATA_WIDTH
) (
    input  logic                         clk,
    input  sis_pkg::cell_ctrl_t          ctrl,
    input  logic signed [DATA_WIDTH-1:0] new_value,
    input  logic signed [DATA_WIDTH-1:0] upper_value,
    input  logic signed [DATA_WIDTH-1:0] lower_value,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic                         keep
);
    import sis_pkg::*;

    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;

    // Stored value stays above a new value that is not greater
    assign keep  = ctrl.occupied && (value_reg >= new_value);
    assign value = value_reg;

    // Next value
    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                if (keep)
                begin
                    value_next = value_reg;
                end
                else if (ctrl.upper_keep)
                begin
                    value_next = new_value;
                end
                else
                begin
                    value_next = upper_value;
                end
            end
            CELL_POP:
            begin
                value_next = lower_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Value register, payload only
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

### src/stack_insertion_sorter_core.sv
// ----------------------------------------------------------------------------
// stack_insertion_sorter_core: descending sort of a run of signed values
// A chain of compare-and-shift cells keeps the run sorted as it arrives and
// shifts it out from the top, largest value first.
// ----------------------------------------------------------------------------
// While a run fills, one value is accepted per cycle: every cell compares
// itself with the new value in parallel and the chain opens a slot in the same
// cycle. Up to DEPTH values are kept; further values are dropped and the final
// result reports it in overflow. After the item with end_of_run is accepted,
// input stops and the run comes out, one result per cycle while result.ready
// is high (fill count results, the first one in the cycle after that item),
// by shifting the chain toward its top; the final result carries last. Input
// opens again once the final result is taken.
// ----------------------------------------------------------------------------
module stack_insertion_sorter_core #(
    parameter int DEPTH      = sis_pkg::SIS_DEPTH,
    parameter int DATA_WIDTH = sis_pkg::SIS_DATA_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sis_in_if.sink     sample,
    sis_out_if.source  result
);
    import sis_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    sis_state_t    state_reg;
    sis_state_t    state_next;
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] fill_count_next;
    logic          dropped_reg;
    logic          dropped_next;

    logic          in_fire;
    logic          out_fire;
    logic          full;
    logic          is_last;
    cell_op_t      op;

    cell_ctrl_t                   ctrl       [DEPTH];
    logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];
    logic                         cell_keep  [DEPTH];

    // Handshakes and status
    assign in_fire  = sample.valid && sample.ready;
    assign out_fire = result.valid && result.ready;
    assign full     = (fill_count_reg == CW'(DEPTH));
    assign is_last  = (fill_count_reg == CW'(1));

    // Chain operation for this cycle
    always_comb
    begin
        if (in_fire && !full)
        begin
            op = CELL_INSERT;
        end
        else if (out_fire)
        begin
            op = CELL_POP;
        end
        else
        begin
            op = CELL_HOLD;
        end
    end

    // Cell chain, cell 0 on top
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign ctrl[i].op         = op;
        assign ctrl[i].occupied   = (CW'(i) < fill_count_reg);
        assign ctrl[i].upper_keep = (i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1];

        sis_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl[i]),
            .new_value   (sample.value),
            .upper_value (cell_value[(i == 0) ? 0 : i - 1]),
            .lower_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
            .value       (cell_value[i]),
            .keep        (cell_keep[i])
        );
    end

    // Sequencer: next state, counters and handshake outputs
    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        dropped_next    = dropped_reg;
        sample.ready    = 1'b0;
        result.valid    = 1'b0;
        unique case (state_reg)
            ST_FILL:
            begin
                sample.ready = 1'b1;
                if (in_fire)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fill_count_next = fill_count_reg + CW'(1);
                    end
                    if (sample.end_of_run)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                result.valid = 1'b1;
                if (out_fire)
                begin
                    fill_count_next = fill_count_reg - CW'(1);
                    if (is_last)
                    begin
                        dropped_next = 1'b0;
                        state_next   = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
        end
    end

    // Result payload straight from the top cell
    assign result.sorted_value = cell_value[0];
    assign result.last         = is_last;
    assign result.overflow     = is_last && dropped_reg;

endmodule
